FILE: sv/assert_macros.svh
// Assertion macros used by the encoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising clock edge, disabled while reset is applied.
`define AVE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Same check, also evaluated during reset.
`define AVE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: sv/avenc_pkg.sv
// Shared types and constants of the value encoder.
package avenc_pkg;

  localparam int unsigned MaxBytes = 10;

  localparam logic [4:0] KIND_NULL      = 5'd0;
  localparam logic [4:0] KIND_BOOL      = 5'd1;
  localparam logic [4:0] KIND_UINT      = 5'd2;
  localparam logic [4:0] KIND_ULONG     = 5'd3;
  localparam logic [4:0] KIND_INT       = 5'd4;
  localparam logic [4:0] KIND_LONG      = 5'd5;
  localparam logic [4:0] KIND_TIMESTAMP = 5'd6;
  localparam logic [4:0] KIND_DOUBLE    = 5'd7;
  localparam logic [4:0] KIND_UUID      = 5'd8;
  localparam logic [4:0] KIND_BINARY    = 5'd9;
  localparam logic [4:0] KIND_STRING    = 5'd10;
  localparam logic [4:0] KIND_SYMBOL    = 5'd11;
  localparam logic [4:0] KIND_RAW       = 5'd12;
  localparam logic [4:0] KIND_LIST      = 5'd13;
  localparam logic [4:0] KIND_MAP       = 5'd14;
  localparam logic [4:0] KIND_END       = 5'd15;
  localparam logic [4:0] KIND_EMPTYLIST = 5'd16;
  localparam logic [4:0] KIND_OPAQUE    = 5'd17;
  localparam logic [4:0] KIND_DESCR     = 5'd18;

  // One queued job for the byte serializer.
  typedef struct packed {
    logic [31:0]                  base;
    logic [MaxBytes-1:0][7:0]     bytes;  // index 0 leaves first
    logic [3:0]                   n;
    logic                         patch;
    logic                         err;
  } cmd_t;

endpackage

FILE: sv/amqp_value_encoder_top.sv
// Top level of the AMQP 1.0 value encoder.
// The slave stream carries one encode command per transfer; the master stream
// carries the resulting wire bytes, one byte per transfer, each tagged with
// its offset in the composed stream. tlast marks the final byte of a command.
// Patch bytes rewrite the length and count words of a closed list32/map32,
// and a stack overflow or an end without an open composite yields a single
// error transfer with data zero.
// The front end decodes a command in the cycle it is accepted and updates all
// offset and composite state there, so commands can arrive back to back. It
// hands a job to a two-entry queue; the serializer behind it sends one byte
// per cycle while the receiver takes them. A job has 1 to 10 bytes, and
// commands with no bytes are accepted but queue no job. The first byte goes
// through the queue and then the output register before it appears.
// When the receiver stalls, the output register holds its byte and the queue
// fills; the slave side then stops accepting until a slot frees.
// Reset clears the stream offset, the nesting depth and the queue; the stack
// memory needs no clearing since only entries written by a start are read.
module amqp_value_encoder_top import avenc_pkg::*; #(
  parameter int unsigned MAX_NESTING = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // kind[4:0], value[68:5], raw_bytes[72:69], opaque_count[104:73], zero fill
  input  logic [111:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // offset[31:0], data[39:32]
  output logic [39:0]  m_axis_tdata,
  // is_patch[0], error[1]
  output logic [1:0]   m_axis_tuser,
  output logic         m_axis_tlast
);

  logic cmd_valid, cmd_ready;
  cmd_t cmd;

  avenc_front #(.MaxNesting(MAX_NESTING)) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (s_axis_tvalid),
    .ready_o        (s_axis_tready),
    .kind_i         (s_axis_tdata[4:0]),
    .value_i        (s_axis_tdata[68:5]),
    .raw_bytes_i    (s_axis_tdata[72:69]),
    .opaque_count_i (s_axis_tdata[104:73]),
    .cmd_valid_o    (cmd_valid),
    .cmd_ready_i    (cmd_ready),
    .cmd_o          (cmd)
  );

  avenc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .offset_o    (m_axis_tdata[31:0]),
    .data_o      (m_axis_tdata[39:32]),
    .is_patch_o  (m_axis_tuser[0]),
    .error_o     (m_axis_tuser[1]),
    .last_o      (m_axis_tlast)
  );

endmodule

FILE: sv/avenc_ram.sv
// Generic single-write, single-read RAM with registered read and write bypass.
module avenc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 8,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (we_i && (waddr_i == raddr_i)) begin
      rdata_q <= wdata_i;
    end else begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/avenc_front.sv
// Front end: decodes commands, tracks offsets and the composite stack.
module avenc_front import avenc_pkg::*; #(
  parameter int unsigned MaxNesting = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  logic [4:0]    kind_i,
  input  logic [63:0]   value_i,
  input  logic [3:0]    raw_bytes_i,
  input  logic [31:0]   opaque_count_i,
  output logic          cmd_valid_o,
  input  logic          cmd_ready_i,
  output cmd_t          cmd_o
);

  localparam int unsigned DW = $clog2(MaxNesting + 1);
  localparam int unsigned AW = (MaxNesting > 1) ? $clog2(MaxNesting) : 1;

  typedef struct packed {
    logic [MaxBytes-1:0][7:0] b;
    logic [3:0]               n;
  } enc_t;

  function automatic enc_t enc_ulong(input logic [63:0] v);
    enc_t e;
    e = '0;
    if (v == 64'd0) begin
      e.b[0] = 8'h44;
      e.n = 4'd1;
    end else if (v[63:8] == 56'd0) begin
      e.b[0] = 8'h53;
      e.b[1] = v[7:0];
      e.n = 4'd2;
    end else begin
      e.b[0] = 8'h80;
      for (int i = 0; i < 8; i++) e.b[1+i] = v[63-8*i -: 8];
      e.n = 4'd9;
    end
    return e;
  endfunction

  logic [31:0]   off_q, off_d;
  logic [DW-1:0] depth_q, depth_d;
  logic [31:0]   top_pos_q, top_pos_d, top_len_q, top_len_d, top_cnt_q, top_cnt_d;
  logic          accept;
  logic          ram_we;
  logic [95:0]   ram_wdata, ram_rdata;
  logic [DW-1:0] wr_idx, rd_idx;
  enc_t          e, u;
  logic          err, patch;
  logic [31:0]   v32;
  logic [3:0]    nraw;
  logic          open;

  assign ready_o = cmd_ready_i;
  assign accept  = valid_i && cmd_ready_i;
  assign v32     = value_i[31:0];
  assign open    = (depth_q != '0);
  assign wr_idx  = depth_q - DW'(1);
  assign rd_idx  = depth_d - DW'(2);

  avenc_ram #(.Width(96), .Depth(MaxNesting)) u_stack (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_idx[AW-1:0]),
    .wdata_i (ram_wdata),
    .raddr_i (rd_idx[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    e = '0;
    u = enc_ulong(value_i);
    err = 1'b0;
    patch = 1'b0;
    nraw = (raw_bytes_i > 4'd8) ? 4'd8 : raw_bytes_i;
    off_d = off_q;
    depth_d = depth_q;
    top_pos_d = top_pos_q;
    top_len_d = top_len_q;
    top_cnt_d = top_cnt_q;
    ram_we = 1'b0;
    ram_wdata = '0;

    case (kind_i)
      KIND_NULL: begin
        e.b[0] = 8'h40; e.n = 4'd1;
      end
      KIND_BOOL: begin
        e.b[0] = (value_i != 64'd0) ? 8'h41 : 8'h42; e.n = 4'd1;
      end
      KIND_UINT: begin
        if (v32 == 32'd0) begin
          e.b[0] = 8'h43; e.n = 4'd1;
        end else if (v32[31:8] == 24'd0) begin
          e.b[0] = 8'h52; e.b[1] = v32[7:0]; e.n = 4'd2;
        end else begin
          e.b[0] = 8'h70;
          for (int i = 0; i < 4; i++) e.b[1+i] = v32[31-8*i -: 8];
          e.n = 4'd5;
        end
      end
      KIND_ULONG: e = u;
      KIND_INT: begin
        if ((v32[31:7] == '0) || (v32[31:7] == '1)) begin
          e.b[0] = 8'h54; e.b[1] = v32[7:0]; e.n = 4'd2;
        end else begin
          e.b[0] = 8'h71;
          for (int i = 0; i < 4; i++) e.b[1+i] = v32[31-8*i -: 8];
          e.n = 4'd5;
        end
      end
      KIND_LONG: begin
        if ((value_i[63:7] == '0) || (value_i[63:7] == '1)) begin
          e.b[0] = 8'h55; e.b[1] = value_i[7:0]; e.n = 4'd2;
        end else begin
          e.b[0] = 8'h81;
          for (int i = 0; i < 8; i++) e.b[1+i] = value_i[63-8*i -: 8];
          e.n = 4'd9;
        end
      end
      KIND_TIMESTAMP, KIND_DOUBLE: begin
        e.b[0] = (kind_i == KIND_TIMESTAMP) ? 8'h83 : 8'h82;
        for (int i = 0; i < 8; i++) e.b[1+i] = value_i[63-8*i -: 8];
        e.n = 4'd9;
      end
      KIND_UUID: begin
        e.b[0] = 8'h98; e.n = 4'd1;
      end
      KIND_BINARY, KIND_STRING, KIND_SYMBOL: begin
        if (v32[31:8] == 24'd0) begin
          e.b[0] = (kind_i == KIND_BINARY) ? 8'hA0 :
                   (kind_i == KIND_STRING) ? 8'hA1 : 8'hA3;
          e.b[1] = v32[7:0];
          e.n = 4'd2;
        end else begin
          e.b[0] = (kind_i == KIND_BINARY) ? 8'hB0 :
                   (kind_i == KIND_STRING) ? 8'hB1 : 8'hB3;
          for (int i = 0; i < 4; i++) e.b[1+i] = v32[31-8*i -: 8];
          e.n = 4'd5;
        end
      end
      KIND_RAW: begin
        for (int i = 0; i < 8; i++) e.b[i] = value_i[63-8*i -: 8];
        e.n = nraw;
      end
      KIND_LIST, KIND_MAP: begin
        if (depth_q == DW'(MaxNesting)) begin
          err = 1'b1; e.n = 4'd1;
        end else begin
          e.b[0] = (kind_i == KIND_MAP) ? 8'hD1 : 8'hD0;
          e.n = 4'd9;
        end
      end
      KIND_END: begin
        if (!open) begin
          err = 1'b1; e.n = 4'd1;
        end else begin
          patch = 1'b1;
          for (int i = 0; i < 4; i++) begin
            e.b[i]   = top_len_q[31-8*i -: 8];
            e.b[4+i] = top_cnt_q[31-8*i -: 8];
          end
          e.n = 4'd8;
        end
      end
      KIND_EMPTYLIST: begin
        e.b[0] = 8'h45; e.n = 4'd1;
      end
      KIND_OPAQUE: ;
      KIND_DESCR: begin
        e.b = {u.b[MaxBytes-2:0], 8'h00};
        e.n = u.n + 4'd1;
      end
      default: ;
    endcase

    if (accept && !err) begin
      if (patch) begin
        depth_d = depth_q - DW'(1);
        if (depth_q > DW'(1)) begin
          top_pos_d = ram_rdata[95:64];
          top_len_d = ram_rdata[63:32] + top_len_q - 32'd4;
          top_cnt_d = ram_rdata[31:0] + 32'd1;
        end
      end else begin
        off_d = off_q + 32'(e.n);
        if (open) begin
          top_len_d = top_len_q + 32'(e.n);
          if (kind_i == KIND_OPAQUE) begin
            top_len_d = top_len_q + v32;
            top_cnt_d = top_cnt_q + opaque_count_i;
          end else if (kind_i != KIND_RAW && kind_i != KIND_LIST &&
                       kind_i != KIND_MAP && kind_i <= KIND_DESCR) begin
            top_cnt_d = top_cnt_q + 32'd1;
          end
        end
        if (kind_i == KIND_LIST || kind_i == KIND_MAP) begin
          // Save the enclosing composite, then open the new one.
          ram_we = open;
          ram_wdata = {top_pos_q, top_len_d, top_cnt_d};
          top_pos_d = off_q + 32'd1;
          top_len_d = 32'd4;
          top_cnt_d = 32'd0;
          depth_d = depth_q + DW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q   <= '0;
      depth_q <= '0;
    end else begin
      off_q   <= off_d;
      depth_q <= depth_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_pos_q <= top_pos_d;
    top_len_q <= top_len_d;
    top_cnt_q <= top_cnt_d;
  end

  assign cmd_valid_o = accept && (e.n != 4'd0);
  always_comb begin
    cmd_o = '0;
    cmd_o.base  = patch ? top_pos_q : off_q;
    cmd_o.bytes = err ? '0 : e.b;
    cmd_o.n     = e.n;
    cmd_o.patch = patch;
    cmd_o.err   = err;
  end

endmodule

FILE: sv/avenc_back.sv
// Back end: two-entry job queue and a one-byte-per-cycle serializer that holds while the receiver stalls.
module avenc_back import avenc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cmd_valid_i,
  output logic        cmd_ready_o,
  input  cmd_t        cmd_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] offset_o,
  output logic [7:0]  data_o,
  output logic        is_patch_o,
  output logic        error_o,
  output logic        last_o
);

  `include "assert_macros.svh"

  cmd_t        q_mem_q [2];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  cnt_q;
  logic [3:0]  idx_q;
  cmd_t        head;
  logic        push, pop, load, fin;
  logic        out_valid_q, out_patch_q, out_err_q, out_last_q;
  logic [31:0] out_off_q;
  logic [7:0]  out_data_q;

  assign cmd_ready_o = (cnt_q != 2'd2);
  assign push = cmd_valid_i && cmd_ready_o;
  assign head = q_mem_q[rd_ptr_q];
  assign load = !out_valid_q || out_ready_i;
  assign fin  = (idx_q == head.n - 4'd1);
  assign pop  = load && (cnt_q != 2'd0) && fin;

  always_ff @(posedge clk_i) begin
    if (push) q_mem_q[wr_ptr_q] <= cmd_i;
    if (load && cnt_q != 2'd0) begin
      out_off_q   <= head.base + 32'(idx_q);
      out_data_q  <= head.bytes[idx_q];
      out_patch_q <= head.patch;
      out_err_q   <= head.err;
      out_last_q  <= fin;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q    <= 1'b0;
      rd_ptr_q    <= 1'b0;
      cnt_q       <= 2'd0;
      idx_q       <= 4'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (push) wr_ptr_q <= !wr_ptr_q;
      if (pop) rd_ptr_q <= !rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
      if (load && cnt_q != 2'd0) begin
        idx_q <= fin ? 4'd0 : idx_q + 4'd1;
      end
      if (load) out_valid_q <= (cnt_q != 2'd0);
    end
  end

  assign out_valid_o = out_valid_q;
  assign offset_o    = out_off_q;
  assign data_o      = out_data_q;
  assign is_patch_o  = out_patch_q;
  assign error_o     = out_err_q;
  assign last_o      = out_last_q;

  `AVE_ASSERT(a_cnt_bound, cnt_q <= 2'd2, "queue count out of range")
  `AVE_ASSERT(a_idx_bound, (cnt_q != 2'd0) |-> (idx_q < head.n), "byte index past job")
  `AVE_ASSERT(a_err_single, (out_valid_q && out_err_q) |-> out_last_q, "error not single")

endmodule
